// ===== rtl/core/section_index_allocator_defines.svh =====
// Assertion macros used by the allocator checker
`ifndef SECTION_INDEX_ALLOCATOR_DEFINES_SVH
`define SECTION_INDEX_ALLOCATOR_DEFINES_SVH

// Checked on every rising clock edge, switched off while reset is held
`define SIA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included
`define SIA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/sia_pkg.sv =====
// Constants and codes for the section index allocator
`timescale 1ns / 1ps

package sia_pkg;

  // Pool sizing: indices are 6 bits, so the pool is capped at 64 slots
  localparam int unsigned MAX_SECTIONS = 64;
  localparam int unsigned SLOT_LIMIT   = 64;
  localparam int unsigned POOL_SIZE    = (MAX_SECTIONS < SLOT_LIMIT) ? MAX_SECTIONS
                                                                     : SLOT_LIMIT;
  localparam int unsigned IDX_W        = $clog2(SLOT_LIMIT);
  localparam int unsigned CNT_W        = $clog2(SLOT_LIMIT + 1);
  localparam int unsigned STATUS_W     = 3;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Request operations
  localparam logic OP_ALLOCATE = 1'b0;
  localparam logic OP_RELEASE  = 1'b1;

  // Response status codes
  localparam status_t ST_ALLOCATED    = 3'd0;
  localparam status_t ST_FULL         = 3'd1;
  localparam status_t ST_RELEASED     = 3'd2;
  localparam status_t ST_OUT_OF_RANGE = 3'd3;
  localparam status_t ST_ALREADY_FREE = 3'd4;

endpackage

// ===== rtl/core/section_index_allocator.sv =====
// Section index allocator: LIFO free stack plus high-water counter
//
// Request channel (req_valid / req_stall): operation 0 allocates an index,
// operation 1 releases slot_index. A word is taken when req_valid is high
// and req_stall is low. Response channel (rsp_valid / rsp_stall): one word
// per request, carrying status and granted_index.
// Each request passes S_IDLE, where its accept launches reads of the free
// stack top and of the vacancy flag, and S_EXEC, which evaluates and writes
// back; the memories' registered reads need this split. The request side
// stalls in S_EXEC, and the response is registered as S_EXEC completes.
// The response sits in an output register, so a new request is accepted
// while an earlier response still waits to be taken. If the receiver keeps
// rsp_stall high, the block holds its result and stalls the request side.
// Reset (rst, synchronous) empties the free stack, clears the high-water
// count and clears the vacancy flags at once; no clearing pass is needed.
// The free stack contents are undefined until written.
`timescale 1ns / 1ps

module section_index_allocator
  import sia_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_stall,
  input  logic    operation,
  input  idx_t    slot_index,
  output logic    rsp_valid,
  input  logic    rsp_stall,
  output status_t status,
  output idx_t    granted_index
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic op_code;
  idx_t op_idx;

  cnt_t free_depth, free_depth_next;
  cnt_t high_water, high_water_next;

  // Free stack memory
  idx_t stack_mem [SLOT_LIMIT];
  idx_t stack_q;
  idx_t stack_raddr;
  logic stack_we;
  idx_t stack_waddr;

  // Vacancy flags: memory plus per-entry valid bits cleared by reset
  logic                  vac_mem [SLOT_LIMIT];
  logic                  vac_q;
  logic [SLOT_LIMIT-1:0] vac_vld;
  logic                  vac_we;
  idx_t                  vac_waddr;
  logic                  vac_wdata;
  logic                  vacant;

  logic    req_take;
  logic    exec_fire;
  cnt_t    depth_dec;
  status_t status_next;
  idx_t    grant_next;

  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign exec_fire = (state == S_EXEC) && (!rsp_valid || !rsp_stall);
  assign depth_dec = free_depth - cnt_t'(1);
  assign stack_raddr = depth_dec[IDX_W-1:0];
  assign vacant    = vac_vld[op_idx] & vac_q;

  // Memory ports: reads launched on accept, writes on completion
  always_ff @(posedge clk) begin
    if (req_take) begin
      stack_q <= stack_mem[stack_raddr];
      vac_q   <= vac_mem[slot_index];
    end
    if (stack_we) begin
      stack_mem[stack_waddr] <= op_idx;
    end
    if (vac_we) begin
      vac_mem[vac_waddr] <= vac_wdata;
    end
  end

  // Evaluate the request against the read data
  always_comb begin
    status_next     = ST_ALLOCATED;
    grant_next      = '0;
    free_depth_next = free_depth;
    high_water_next = high_water;
    stack_we        = 1'b0;
    stack_waddr     = free_depth[IDX_W-1:0];
    vac_we          = 1'b0;
    vac_waddr       = op_idx;
    vac_wdata       = 1'b0;
    if (op_code == OP_ALLOCATE) begin
      if (free_depth != '0) begin
        // pop the most recently released index
        grant_next      = stack_q;
        free_depth_next = depth_dec;
        vac_we          = exec_fire;
        vac_waddr       = stack_q;
        vac_wdata       = 1'b0;
      end else if (high_water < cnt_t'(POOL_SIZE)) begin
        // hand out a fresh index
        grant_next      = high_water[IDX_W-1:0];
        high_water_next = high_water + cnt_t'(1);
      end else begin
        status_next = ST_FULL;
      end
    end else begin
      if ({1'b0, op_idx} >= high_water) begin
        status_next = ST_OUT_OF_RANGE;
      end else if (vacant) begin
        status_next = ST_ALREADY_FREE;
      end else begin
        status_next = ST_RELEASED;
        // guarded push; a full stack cannot occur with distinct indices
        if (free_depth < cnt_t'(SLOT_LIMIT)) begin
          stack_we        = exec_fire;
          free_depth_next = free_depth + cnt_t'(1);
          vac_we          = exec_fire;
          vac_waddr       = op_idx;
          vac_wdata       = 1'b1;
        end
      end
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (req_take) begin
      op_code <= operation;
      op_idx  <= slot_index;
    end
  end

  // Control state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_depth <= '0;
      high_water <= '0;
      vac_vld    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_take) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_fire) begin
            state      <= S_IDLE;
            free_depth <= free_depth_next;
            high_water <= high_water_next;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (vac_we) begin
        vac_vld[vac_waddr] <= 1'b1;
      end
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (exec_fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      status        <= status_next;
      granted_index <= grant_next;
    end
  end

endmodule

// ===== rtl/core/sia_checker.sv =====
// Port-level checker for the section index allocator, bound to the top level
`timescale 1ns / 1ps
`include "section_index_allocator_defines.svh"

module sia_checker
  import sia_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    req_valid,
  input logic    req_stall,
  input logic    operation,
  input idx_t    slot_index,
  input logic    rsp_valid,
  input logic    rsp_stall,
  input status_t status,
  input idx_t    granted_index
);

  // a stalled request word holds until taken
  `SIA_ASSERT(a_req_hold, req_valid && req_stall |=> req_valid && $stable(operation) && $stable(slot_index), "request changed while stalled")

  // a stalled response word holds
  `SIA_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(granted_index), "response changed while stalled")

  // only defined status codes leave the block
  `SIA_ASSERT(a_status_code, rsp_valid |-> (status == ST_ALLOCATED || status == ST_FULL || status == ST_RELEASED || status == ST_OUT_OF_RANGE || status == ST_ALREADY_FREE), "undefined status code")

  // granted index is zero unless an index was allocated
  `SIA_ASSERT(a_grant_zero, rsp_valid && (status != ST_ALLOCATED) |-> granted_index == '0, "granted index set on non-allocate status")

  // reset leaves no response pending
  `SIA_ASSERT_ALWAYS(a_rst_clear, rst |=> !rsp_valid, "response valid after reset")

endmodule

bind section_index_allocator sia_checker u_sia_checker (.*);
